// ===== sv/spf_pkg.sv =====
// Shared types, constants and helpers for the stuffed packet framer.
// Used by the channel interfaces and every framer module; depends on nothing.
package spf_pkg;

   // Field widths of the request and response channels
   localparam int KIND_W  = 1;
   localparam int TYPE_W  = 8;
   localparam int LEN_W   = 10;
   localparam int COUNT_W = 31;
   localparam int BYTE_W  = 8;

   // Default size of the frame buffer; payload is capped at this minus framing
   localparam int FRAME_BUFFER_BYTES_DEFAULT = 1024;
   localparam int FRAME_OVERHEAD = 14;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_START = 1'b0;
   localparam logic [KIND_W-1:0] KIND_DATA  = 1'b1;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      CMD_START,
      CMD_DATA
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type           op;
      logic                 last;          // trailer follows this command
      logic [TYPE_W-1:0]    packet_type;
      logic [LEN_W-1:0]     data_length;
      logic [COUNT_W-1:0]   seq_count;
      logic [BYTE_W-1:0]    data_byte;
   } cmd_type;

   // Byte positions walked by the back end
   typedef enum logic [3:0] {
      STEP_LEAD0,
      STEP_LEAD1,
      STEP_TYPE,
      STEP_LEN0,
      STEP_LEN1,
      STEP_LEN2,
      STEP_LEN3,
      STEP_CNT0,
      STEP_CNT1,
      STEP_CNT2,
      STEP_CNT3,
      STEP_DATA,
      STEP_CHECK,
      STEP_TRAIL0,
      STEP_TRAIL1
   } step_type;

   // Byte substitutions that keep zero and one out of the frame body
   localparam logic [BYTE_W-1:0] SUBST_ZERO = 8'd12;
   localparam logic [BYTE_W-1:0] SUBST_ONE  = 8'd13;

   function automatic logic [BYTE_W-1:0] subst_byte(input logic [BYTE_W-1:0] raw);
      logic [BYTE_W-1:0] result;
      begin
         result = raw;
         if (raw == 8'd0) begin
            result = SUBST_ZERO;
         end else if (raw == 8'd1) begin
            result = SUBST_ONE;
         end
         return result;
      end
   endfunction

endpackage

// ===== sv/spf_req_if.sv =====
// Request channel of the stuffed packet framer: valid/ready plus item fields.
// Depends on spf_pkg for field widths.
interface spf_req_if import spf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [TYPE_W-1:0]    packet_type;
   logic [LEN_W-1:0]     data_length;
   logic [COUNT_W-1:0]   seq_count;
   logic [BYTE_W-1:0]    data_byte;

   modport source (
      output valid, kind, packet_type, data_length, seq_count, data_byte,
      input  ready
   );
   modport sink (
      input  valid, kind, packet_type, data_length, seq_count, data_byte,
      output ready
   );
endinterface

// Response channel: one framed byte per handshake.
interface spf_rsp_if import spf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   frame_byte;
   logic                frame_end;

   modport source (output valid, frame_byte, frame_end, input ready);
   modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

// ===== sv/spf_front.sv =====
// Front end of the framer: accepts requests, tracks the open frame and
// turns useful requests into queue commands. Depends on spf_pkg, spf_req_if.
module spf_front
   import spf_pkg::*;
#(
   parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   spf_req_if.sink   req_if,
   input  logic      queue_full,
   output logic      push,
   output cmd_type   push_cmd
);

   localparam logic [16:0] MaxPayload = 17'(FRAME_BUFFER_BYTES - FRAME_OVERHEAD);

   logic              in_frame_ff, in_frame_in;
   logic [LEN_W-1:0]  remaining_ff, remaining_in;
   logic [LEN_W-1:0]  len_sat;
   logic              accept;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;

   // Cap the payload length at what the frame buffer holds
   always_comb begin
      len_sat = req_if.data_length;
      if ({7'd0, req_if.data_length} > MaxPayload) begin
         len_sat = MaxPayload[LEN_W-1:0];
      end
   end

   // Classify the request and update frame tracking
   always_comb begin
      in_frame_in           = in_frame_ff;
      remaining_in          = remaining_ff;
      push                  = 1'b0;
      push_cmd.op           = CMD_START;
      push_cmd.last         = 1'b0;
      push_cmd.packet_type  = req_if.packet_type;
      push_cmd.data_length  = len_sat;
      push_cmd.seq_count    = req_if.seq_count;
      push_cmd.data_byte    = req_if.data_byte;
      if (accept) begin
         if (req_if.kind == KIND_START) begin
            push          = 1'b1;
            push_cmd.last = (len_sat == '0);
            in_frame_in   = (len_sat != '0);
            remaining_in  = len_sat;
         end else if (in_frame_ff && remaining_ff != '0) begin
            // Drop stray data silently; only in-frame bytes go on
            push          = 1'b1;
            push_cmd.op   = CMD_DATA;
            push_cmd.last = (remaining_ff == LEN_W'(1));
            remaining_in  = remaining_ff - LEN_W'(1);
            in_frame_in   = (remaining_ff != LEN_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         remaining_ff <= '0;
      end else begin
         in_frame_ff  <= in_frame_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

// ===== sv/spf_cmd_queue.sv =====
// Short command queue between the framer front and back ends.
// Depends on spf_pkg for the command type and depth.
module spf_cmd_queue
   import spf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output cmd_type  pop_cmd
);

   cmd_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]  count_ff;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QUEUE_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QUEUE_CNT_W'(1);
         end
      end
   end

endmodule

// ===== sv/spf_back.sv =====
// Back end of the framer: walks each command through its frame bytes,
// keeps the checksum and drives the response register. Depends on spf_pkg.
module spf_back
   import spf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   spf_rsp_if.source rsp_if
);

   cmd_type            cur_ff, cur_in;
   step_type           step_ff, step_in;
   logic               busy_ff, busy_in;
   logic [BYTE_W-1:0]  check_ff, check_in;
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_end_ff, out_end_in;

   logic               advance, emit, last_step, done;
   logic [BYTE_W-1:0]  raw_byte, frame_byte;

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.frame_byte = out_byte_ff;
   assign rsp_if.frame_end  = out_end_ff;

   assign advance   = !out_valid_ff || rsp_if.ready;
   assign emit      = busy_ff && advance;
   assign last_step = ((step_ff == STEP_CNT3 || step_ff == STEP_DATA) && !cur_ff.last)
                      || (step_ff == STEP_TRAIL1);
   assign done      = emit && last_step;
   assign cmd_pop   = cmd_valid && (!busy_ff || done);

   // Select the raw byte for the current position
   always_comb begin
      case (step_ff)
         STEP_TYPE:  raw_byte = cur_ff.packet_type;
         STEP_LEN0:  raw_byte = cur_ff.data_length[7:0];
         STEP_LEN1:  raw_byte = {6'd0, cur_ff.data_length[LEN_W-1:8]};
         STEP_CNT0:  raw_byte = cur_ff.seq_count[7:0];
         STEP_CNT1:  raw_byte = cur_ff.seq_count[15:8];
         STEP_CNT2:  raw_byte = cur_ff.seq_count[23:16];
         STEP_CNT3:  raw_byte = {1'b0, cur_ff.seq_count[COUNT_W-1:24]};
         STEP_DATA:  raw_byte = cur_ff.data_byte;
         STEP_CHECK: raw_byte = check_ff;
         default:    raw_byte = 8'd0;
      endcase
   end

   // Substitute body bytes; leading and trailing zeros pass as they are
   always_comb begin
      frame_byte = raw_byte;
      if (step_ff inside {[STEP_TYPE:STEP_CHECK]}) begin
         frame_byte = subst_byte(raw_byte);
      end
   end

   // Sequence bytes, load the next command, accumulate the checksum
   always_comb begin
      cur_in       = cur_ff;
      step_in      = step_ff;
      busy_in      = busy_ff;
      check_in     = check_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;

      if (advance) begin
         out_valid_in = busy_ff;
         out_byte_in  = frame_byte;
         out_end_in   = (step_ff == STEP_TRAIL1);
      end

      if (emit) begin
         if (step_ff == STEP_LEAD0) begin
            check_in = 8'd0;
         end else if (step_ff inside {[STEP_TYPE:STEP_DATA]}) begin
            check_in = check_ff ^ raw_byte;
         end
         if (step_ff == STEP_CNT3) begin
            step_in = STEP_CHECK;
         end else begin
            step_in = step_type'(step_ff + 4'd1);
         end
      end

      if (cmd_pop) begin
         cur_in  = cmd;
         busy_in = 1'b1;
         step_in = (cmd.op == CMD_START) ? STEP_LEAD0 : STEP_DATA;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         step_ff      <= STEP_LEAD0;
         check_ff     <= 8'd0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
         check_ff     <= check_in;
      end
   end

   // Hold payload registers without reset
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
   end

endmodule

// ===== sv/stuffed_packet_framer_core.sv =====
// Stuffed packet framer, top level.
// Request channel (req_if): kind 0 opens a frame with type, length and
// packet counter; kind 1 carries one payload byte. Data outside a frame or
// beyond the given length is accepted and dropped.
// Response channel (rsp_if): one framed byte per handshake, two zero bytes,
// nine substituted header bytes, substituted payload, substituted XOR
// checksum, two zero bytes; frame_end marks the last zero byte.
// The first response byte passes through the queue entry, the command
// register and the response register after the request is accepted.
// Throughput: one payload byte per cycle while the response side is ready;
// a start request yields eleven output bytes (fourteen with zero length)
// and the last data byte four, emitted one byte per unstalled cycle. A
// four-entry command queue absorbs these bursts; ready falls only when full.
// Reset (synchronous) closes any open frame and empties queue and output.
// A stall on the response side holds the output byte and backs up the
// queue; the request side keeps going until the queue fills.
module stuffed_packet_framer_core
   import spf_pkg::*;
#(
   parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   spf_req_if.sink    req_if,
   spf_rsp_if.source  rsp_if
);

   logic     push, queue_full, pop, pop_valid;
   cmd_type  push_cmd, pop_cmd;

   spf_front #(
      .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   spf_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   spf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_pop   (pop),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== sv/spf_checker.sv =====
// Port-level checks for the stuffed packet framer, bound to the top level.
// Depends on spf_pkg and stuffed_packet_framer_core.
module spf_checker
   import spf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [BYTE_W-1:0]  rsp_frame_byte,
   input logic               rsp_frame_end
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte)
                                  && $stable(rsp_frame_end))
      else $error("response changed while stalled");

   // Close each frame on a zero byte
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_frame_byte == 8'd0)
      else $error("frame end on a nonzero byte");

   // Keep the value one out of the stream
   a_no_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_byte != 8'd1)
      else $error("unsubstituted one byte on output");

   // Drop the response right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind stuffed_packet_framer_core spf_checker u_spf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_frame_byte (rsp_if.frame_byte),
   .rsp_frame_end  (rsp_if.frame_end)
);
